// ===== hw/rtl/mandel_pkg.sv =====
// shared types, constants and the microcode table of the mandelbrot escape-time unit
// used by mandel_seq, mandel_dp and mandelbrot_escape_time_top; no dependencies
package mandel_pkg;

   localparam int DEF_IMAGE_WIDTH   = 1024;
   localparam int DEF_IMAGE_HEIGHT  = 1024;
   localparam int DEF_FRACTION_BITS = 28;

   localparam int PIX_W   = 10;
   localparam int DATA_W  = 32;
   localparam int STEP_PW = 31;
   localparam int ITER_W  = 16;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int WIDE_W  = PROD_W + 1;

   // register indexes on the csr port
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_STEP  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_REAL = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_IMAG = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ITER_LIMIT  = 2'd3;

   localparam logic [STEP_PW-1:0] RST_PIXEL_STEP = 31'd1048576;
   localparam logic [ITER_W-1:0]  RST_ITER_LIMIT = 16'd100;

   // microcode addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
   localparam logic [STEP_W-1:0] ST_MAPX  = 4'd1;
   localparam logic [STEP_W-1:0] ST_MAPY  = 4'd2;
   localparam logic [STEP_W-1:0] ST_CY    = 4'd3;
   localparam logic [STEP_W-1:0] ST_SQX   = 4'd4;
   localparam logic [STEP_W-1:0] ST_SQY   = 4'd5;
   localparam logic [STEP_W-1:0] ST_CROSS = 4'd6;
   localparam logic [STEP_W-1:0] ST_UPD   = 4'd7;
   localparam logic [STEP_W-1:0] ST_DONE  = 4'd8;

   typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_type;
   typedef enum logic [1:0] {JMP_NEVER, JMP_ALWAYS, JMP_EXIT} jump_type;
   typedef enum logic [1:0] {OPA_DX, OPA_DY, OPA_ZX, OPA_ZY} opa_type;
   typedef enum logic [1:0] {OPB_STEP, OPB_ZX, OPB_ZY} opb_type;

   typedef struct packed {
      hold_type          hold;
      jump_type          jump;
      logic [STEP_W-1:0] target;
      opa_type           opa;
      opb_type           opb;
      logic              wr_cx;
      logic              wr_cy;
      logic              wr_xx;
      logic              wr_yy;
      logic              wr_z;
   } ucode_type;

   typedef struct packed {
      ucode_type uc;
      logic      take;
      logic      emit;
   } ctrl_type;

   typedef struct packed {
      logic escape;
   } status_type;

   function automatic ucode_type uword(hold_type h, jump_type j, logic [STEP_W-1:0] t,
                                       opa_type a, opb_type b, logic [4:0] wr);
      ucode_type w;
      w.hold   = h;
      w.jump   = j;
      w.target = t;
      w.opa    = a;
      w.opb    = b;
      {w.wr_cx, w.wr_cy, w.wr_xx, w.wr_yy, w.wr_z} = wr;
      return w;
   endfunction

   // write flags in order cx, cy, xx, yy, z
   function automatic ucode_type ucode_rom(logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         ST_WAIT:  w = uword(HOLD_IN,   JMP_NEVER,  ST_WAIT,  OPA_ZX, OPB_ZX,   5'b00000);
         ST_MAPX:  w = uword(HOLD_NONE, JMP_NEVER,  ST_WAIT,  OPA_DX, OPB_STEP, 5'b00000);
         ST_MAPY:  w = uword(HOLD_NONE, JMP_NEVER,  ST_WAIT,  OPA_DY, OPB_STEP, 5'b10000);
         ST_CY:    w = uword(HOLD_NONE, JMP_NEVER,  ST_WAIT,  OPA_ZX, OPB_ZX,   5'b01000);
         ST_SQX:   w = uword(HOLD_NONE, JMP_NEVER,  ST_WAIT,  OPA_ZX, OPB_ZX,   5'b00000);
         ST_SQY:   w = uword(HOLD_NONE, JMP_NEVER,  ST_WAIT,  OPA_ZY, OPB_ZY,   5'b00100);
         ST_CROSS: w = uword(HOLD_NONE, JMP_EXIT,   ST_DONE,  OPA_ZX, OPB_ZY,   5'b00010);
         ST_UPD:   w = uword(HOLD_NONE, JMP_ALWAYS, ST_SQX,   OPA_ZX, OPB_ZX,   5'b00001);
         ST_DONE:  w = uword(HOLD_OUT,  JMP_ALWAYS, ST_WAIT,  OPA_ZX, OPB_ZX,   5'b00000);
         default:  w = uword(HOLD_NONE, JMP_ALWAYS, ST_WAIT,  OPA_ZX, OPB_ZX,   5'b00000);
      endcase
      return w;
   endfunction

   // clamp a wide signed value to the 32-bit signed range
   function automatic logic signed [DATA_W-1:0] sat32(logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 65'sh0_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (v < -65'sh0_8000_0000)
         r = 32'sh8000_0000;
      else
         r = v[DATA_W-1:0];
      return r;
   endfunction

endpackage

// ===== hw/rtl/mandelbrot_escape_time_top.sv =====
// Mandelbrot escape-time unit, top level: csr registers, result register, sequencer and datapath
// depends on mandel_pkg, mandel_seq and mandel_dp
//
// req channel: one beat per pixel (pixel_x, pixel_y). rsp channel: one beat per pixel with
// the coordinates and the escape count. The pixel is mapped to c = (2*pixel - size) * step / 2
// + center and z = z*z + c is iterated from zero while |z|^2 < 4 and the count is below the
// limit. All multiplies go through one 32x32 multiplier under a microcoded sequencer.
// Steps: WAIT accepts the pixel, MAPX, MAPY and CY map it, each iteration runs SQX, SQY,
// CROSS and UPD, the final escape test runs SQX, SQY and CROSS, and DONE loads the result
// register. The multiplier is used in SQX, SQY and CROSS of an iteration and idles in UPD.
// One pixel is in work at a time; the next pixel is accepted as soon as the result sits in
// the output register, even while the receiver still stalls it. A stalled result holds the
// sequencer in its final step once the next one is done.
// csr writes go to registers 0..3 (step, center real, center imag, limit) and must only
// happen while the unit is idle. Reset restores the register defaults and clears rsp_tvalid.
module mandelbrot_escape_time_top #(
   parameter int IMAGE_WIDTH   = mandel_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT  = mandel_pkg::DEF_IMAGE_HEIGHT,
   parameter int FRACTION_BITS = mandel_pkg::DEF_FRACTION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [23:0]                          req_tdata,  // pixel_x, pixel_y, zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [39:0]                          rsp_tdata,  // out_x, out_y, escape_count, pad
   input  logic                                 csr_we,
   input  logic [mandel_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [mandel_pkg::DATA_W-1:0]        csr_wdata
);
   import mandel_pkg::*;

   logic [STEP_PW-1:0]       pixel_step_ff;
   logic signed [DATA_W-1:0] center_real_ff, center_imag_ff;
   logic [ITER_W-1:0]        iteration_limit_ff;

   logic                     rsp_valid_ff;
   logic [PIX_W-1:0]         rsp_x_ff, rsp_y_ff;
   logic [ITER_W-1:0]        rsp_count_ff;

   ctrl_type                 ctrl;
   status_type               status;
   logic                     out_free;
   logic [PIX_W-1:0]         out_x, out_y;
   logic [ITER_W-1:0]        escape_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_step_ff      <= RST_PIXEL_STEP;
         center_real_ff     <= '0;
         center_imag_ff     <= '0;
         iteration_limit_ff <= RST_ITER_LIMIT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_PIXEL_STEP:  pixel_step_ff      <= csr_wdata[STEP_PW-1:0];
            CSR_CENTER_REAL: center_real_ff     <= $signed(csr_wdata);
            CSR_CENTER_IMAG: center_imag_ff     <= $signed(csr_wdata);
            CSR_ITER_LIMIT:  iteration_limit_ff <= csr_wdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   mandel_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .status     (status),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   mandel_dp #(
      .IMAGE_WIDTH   (IMAGE_WIDTH),
      .IMAGE_HEIGHT  (IMAGE_HEIGHT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .ctrl            (ctrl),
      .pixel_x         (req_tdata[PIX_W-1:0]),
      .pixel_y         (req_tdata[2*PIX_W-1:PIX_W]),
      .pixel_step      (pixel_step_ff),
      .center_real     (center_real_ff),
      .center_imag     (center_imag_ff),
      .iteration_limit (iteration_limit_ff),
      .status          (status),
      .out_x           (out_x),
      .out_y           (out_y),
      .escape_count    (escape_count)
   );

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (ctrl.emit)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_x_ff     <= out_x;
         rsp_y_ff     <= out_y;
         rsp_count_ff <= escape_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_y_ff, rsp_x_ff};

   a_beat_from_sequencer: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.emit))
      else $error("result beat appeared without a finished pixel");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> out_free)
      else $error("result register overwritten while stalled");
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> !ctrl.emit && !ctrl.uc.wr_z)
      else $error("pixel accepted while sequencer busy");

endmodule

// ===== hw/rtl/mandel_seq.sv =====
// microcode sequencer: step counter, control word fetch, hold and jump logic
// depends on mandel_pkg
module mandel_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   out_free,
   input  mandel_pkg::status_type status,
   output logic                   req_tready,
   output mandel_pkg::ctrl_type   ctrl
);
   import mandel_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         uc;
   logic              waiting;
   logic              jump_taken;

   assign uc = ucode_rom(step_ff);

   always_comb begin
      unique case (uc.hold)
         HOLD_IN:  waiting = !req_tvalid;
         HOLD_OUT: waiting = !out_free;
         default:  waiting = 1'b0;
      endcase
      unique case (uc.jump)
         JMP_ALWAYS: jump_taken = 1'b1;
         JMP_EXIT:   jump_taken = status.escape;
         default:    jump_taken = 1'b0;
      endcase
      if (waiting)
         step_in = step_ff;
      else if (jump_taken)
         step_in = uc.target;
      else
         step_in = step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         step_ff <= ST_WAIT;
      else
         step_ff <= step_in;
   end

   assign req_tready = (uc.hold == HOLD_IN);
   assign ctrl.uc    = uc;
   assign ctrl.take  = (uc.hold == HOLD_IN) && req_tvalid;
   assign ctrl.emit  = (uc.hold == HOLD_OUT) && out_free;

   a_take_starts_map: assert property (@(posedge clock) disable iff (reset)
      ctrl.take |=> step_ff == ST_MAPX)
      else $error("accepted pixel did not start mapping");
   a_emit_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |=> step_ff == ST_WAIT)
      else $error("sequencer did not return to wait after result");
   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ST_DONE)
      else $error("step counter left the program");

endmodule

// ===== hw/rtl/mandel_dp.sv =====
// datapath: shared 32x32 multiplier, coordinate mapping, z update and escape test
// depends on mandel_pkg; driven by control words from mandel_seq
module mandel_dp #(
   parameter int IMAGE_WIDTH   = mandel_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT  = mandel_pkg::DEF_IMAGE_HEIGHT,
   parameter int FRACTION_BITS = mandel_pkg::DEF_FRACTION_BITS
) (
   input  logic                                    clock,
   input  mandel_pkg::ctrl_type                    ctrl,
   input  logic [mandel_pkg::PIX_W-1:0]            pixel_x,
   input  logic [mandel_pkg::PIX_W-1:0]            pixel_y,
   input  logic [mandel_pkg::STEP_PW-1:0]          pixel_step,
   input  logic signed [mandel_pkg::DATA_W-1:0]    center_real,
   input  logic signed [mandel_pkg::DATA_W-1:0]    center_imag,
   input  logic [mandel_pkg::ITER_W-1:0]           iteration_limit,
   output mandel_pkg::status_type                  status,
   output logic [mandel_pkg::PIX_W-1:0]            out_x,
   output logic [mandel_pkg::PIX_W-1:0]            out_y,
   output logic [mandel_pkg::ITER_W-1:0]           escape_count
);
   import mandel_pkg::*;

   localparam logic signed [DATA_W-1:0] HALF_W = DATA_W'(IMAGE_WIDTH);
   localparam logic signed [DATA_W-1:0] HALF_H = DATA_W'(IMAGE_HEIGHT);
   localparam logic [PROD_W-1:0]        FOUR   = PROD_W'(4) << FRACTION_BITS;

   logic [PIX_W-1:0]         px_ff, py_ff;
   logic signed [DATA_W-1:0] cx_ff, cy_ff, zx_ff, zy_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic signed [PROD_W-1:0] prod_ff, xx_ff, yy_ff;

   logic signed [DATA_W-1:0] dx, dy, opa, opb;
   logic signed [PROD_W-1:0] prod_in, diff;
   logic [PROD_W-1:0]        mag_sum;

   // 2*pixel - size, the factor of two is taken out after the multiply
   assign dx = $signed({{(DATA_W-PIX_W-1){1'b0}}, px_ff, 1'b0}) - HALF_W;
   assign dy = $signed({{(DATA_W-PIX_W-1){1'b0}}, py_ff, 1'b0}) - HALF_H;

   always_comb begin
      case (ctrl.uc.opa)
         OPA_DX:  opa = dx;
         OPA_DY:  opa = dy;
         OPA_ZY:  opa = zy_ff;
         default: opa = zx_ff;
      endcase
      case (ctrl.uc.opb)
         OPB_STEP: opb = $signed({1'b0, pixel_step});
         OPB_ZY:   opb = zy_ff;
         default:  opb = zx_ff;
      endcase
   end

   assign prod_in = opa * opb;
   assign diff    = xx_ff - yy_ff;

   // squares are never negative, so the sum fits unsigned
   assign mag_sum       = $unsigned(xx_ff) + $unsigned(prod_ff);
   assign status.escape = !((mag_sum >> FRACTION_BITS) < FOUR) || (iter_ff >= iteration_limit);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (ctrl.take) begin
         px_ff   <= pixel_x;
         py_ff   <= pixel_y;
         zx_ff   <= '0;
         zy_ff   <= '0;
         iter_ff <= '0;
      end
      if (ctrl.uc.wr_cx)
         cx_ff <= sat32(WIDE_W'(prod_ff >>> 1) + WIDE_W'(center_real));
      if (ctrl.uc.wr_cy)
         cy_ff <= sat32(WIDE_W'(prod_ff >>> 1) + WIDE_W'(center_imag));
      if (ctrl.uc.wr_xx)
         xx_ff <= prod_ff;
      if (ctrl.uc.wr_yy)
         yy_ff <= prod_ff;
      if (ctrl.uc.wr_z) begin
         zx_ff   <= sat32(WIDE_W'(diff >>> FRACTION_BITS) + WIDE_W'(cx_ff));
         zy_ff   <= sat32(WIDE_W'(prod_ff >>> (FRACTION_BITS - 1)) + WIDE_W'(cy_ff));
         iter_ff <= iter_ff + 1'b1;
      end
   end

   assign out_x        = px_ff;
   assign out_y        = py_ff;
   assign escape_count = iter_ff;

   a_update_below_limit: assert property (@(posedge clock)
      ctrl.uc.wr_z |-> iter_ff < iteration_limit)
      else $error("z updated with iteration count at limit");

endmodule
